// ===== hw/rtl/kf2_pkg.sv =====
// kf2_pkg: shared types, constants and helper functions of the two-state kalman tracker
// holds the alu operation codes, operand slot map and the micro-program table
// no dependencies
package kf2_pkg;

	localparam int STATE_W = 48;
	localparam int FRAC_W  = 24;
	localparam int IO_FRAC = 16;
	localparam int LIFT_SH = FRAC_W - IO_FRAC;
	localparam int NUM_W   = STATE_W + FRAC_W;
	localparam int ACC_W   = 2 * STATE_W;
	localparam int HALF_W  = STATE_W / 2;
	localparam int RAD_W   = STATE_W + 8;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int SLOT_W  = 5;

	localparam logic signed [STATE_W-1:0] ST_MAX = {1'b0, {(STATE_W-1){1'b1}}};
	localparam logic signed [STATE_W-1:0] ST_MIN = {1'b1, {(STATE_W-1){1'b0}}};

	// configuration register indexes
	localparam logic [1:0] CFG_TIME_STEP   = 2'd0;
	localparam logic [1:0] CFG_PROC_NOISE  = 2'd1;
	localparam logic [1:0] CFG_MEAS_NOISE  = 2'd2;

	// operation codes of an input beat
	localparam logic [1:0] OPC_PREDICT = 2'd0;
	localparam logic [1:0] OPC_UPDATE  = 2'd1;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_DIV3 = 3'd4,
		OP_HALF = 3'd5,
		OP_SQRT = 3'd6
	} alu_op_t;

	typedef enum logic [1:0] {
		PG_PREDICT = 2'd0,
		PG_UPDATE  = 2'd1,
		PG_INIT    = 2'd2,
		PG_REPORT  = 2'd3
	} prog_t;

	// operand slots
	localparam logic [SLOT_W-1:0] SL_POS   = 5'd0;
	localparam logic [SLOT_W-1:0] SL_RATE  = 5'd1;
	localparam logic [SLOT_W-1:0] SL_P00   = 5'd2;
	localparam logic [SLOT_W-1:0] SL_P01   = 5'd3;
	localparam logic [SLOT_W-1:0] SL_P11   = 5'd4;
	localparam logic [SLOT_W-1:0] SL_DT    = 5'd5;
	localparam logic [SLOT_W-1:0] SL_QN    = 5'd6;
	localparam logic [SLOT_W-1:0] SL_RN    = 5'd7;
	localparam logic [SLOT_W-1:0] SL_HZ    = 5'd8;
	localparam logic [SLOT_W-1:0] SL_ZM    = 5'd9;
	localparam logic [SLOT_W-1:0] SL_ZERO  = 5'd10;
	localparam logic [SLOT_W-1:0] SL_ONE   = 5'd11;
	localparam logic [SLOT_W-1:0] SL_K1000 = 5'd12;
	localparam logic [SLOT_W-1:0] SL_DT2   = 5'd13;
	localparam logic [SLOT_W-1:0] SL_DT3   = 5'd14;
	localparam logic [SLOT_W-1:0] SL_TA    = 5'd15;
	localparam logic [SLOT_W-1:0] SL_TB    = 5'd16;
	localparam logic [SLOT_W-1:0] SL_TC    = 5'd17;
	localparam logic [SLOT_W-1:0] SL_TD    = 5'd18;
	localparam logic [SLOT_W-1:0] SL_S     = 5'd19;
	localparam logic [SLOT_W-1:0] SL_K0    = 5'd20;
	localparam logic [SLOT_W-1:0] SL_K1    = 5'd21;
	localparam logic [SLOT_W-1:0] SL_Y     = 5'd22;
	localparam logic [SLOT_W-1:0] SL_OM    = 5'd23;
	localparam logic [SLOT_W-1:0] SL_FC    = 5'd24;
	localparam logic [SLOT_W-1:0] SL_V     = 5'd25;
	localparam logic [SLOT_W-1:0] SL_H2    = 5'd26;
	localparam logic [SLOT_W-1:0] SL_SD    = 5'd27;

	// micro-op flags: {skip unless gain enable, set gain enable, last of program}
	localparam logic [2:0] F_NONE = 3'b000;
	localparam logic [2:0] F_LAST = 3'b001;
	localparam logic [2:0] F_SETC = 3'b010;
	localparam logic [2:0] F_COND = 3'b100;

	typedef struct packed {
		alu_op_t           op;
		logic [SLOT_W-1:0] src_a;
		logic [SLOT_W-1:0] src_b;
		logic [SLOT_W-1:0] dst;
		logic              cond;
		logic              setc;
		logic              last;
	} micro_t;

	function automatic micro_t mk(alu_op_t op, logic [SLOT_W-1:0] a, logic [SLOT_W-1:0] b,
			logic [SLOT_W-1:0] d, logic [2:0] f);
		micro_t r;
		r.op    = op;
		r.src_a = a;
		r.src_b = b;
		r.dst   = d;
		r.cond  = f[2];
		r.setc  = f[1];
		r.last  = f[0];
		return r;
	endfunction

	function automatic micro_t micro_of(prog_t p, logic [SLOT_W-1:0] s);
		micro_t r;
		r = mk(OP_ADD, SL_ZERO, SL_ZERO, SL_TA, F_LAST);
		unique case (p)
			PG_PREDICT: begin
				case (s)
					5'd0:  r = mk(OP_MUL,  SL_DT,   SL_DT,   SL_DT2,  F_NONE);
					5'd1:  r = mk(OP_MUL,  SL_DT2,  SL_DT,   SL_DT3,  F_NONE);
					5'd2:  r = mk(OP_MUL,  SL_DT,   SL_P01,  SL_TA,   F_NONE);
					5'd3:  r = mk(OP_ADD,  SL_P00,  SL_TA,   SL_TD,   F_NONE);
					5'd4:  r = mk(OP_ADD,  SL_TD,   SL_TA,   SL_TD,   F_NONE);
					5'd5:  r = mk(OP_MUL,  SL_DT2,  SL_P11,  SL_TB,   F_NONE);
					5'd6:  r = mk(OP_ADD,  SL_TD,   SL_TB,   SL_TD,   F_NONE);
					5'd7:  r = mk(OP_MUL,  SL_DT,   SL_P11,  SL_TB,   F_NONE);
					5'd8:  r = mk(OP_ADD,  SL_P01,  SL_TB,   SL_TC,   F_NONE);
					5'd9:  r = mk(OP_MUL,  SL_DT,   SL_RATE, SL_TB,   F_NONE);
					5'd10: r = mk(OP_ADD,  SL_POS,  SL_TB,   SL_POS,  F_NONE);
					5'd11: r = mk(OP_MUL,  SL_QN,   SL_DT3,  SL_TB,   F_NONE);
					5'd12: r = mk(OP_DIV3, SL_TB,   SL_ZERO, SL_TB,   F_NONE);
					5'd13: r = mk(OP_ADD,  SL_TD,   SL_TB,   SL_P00,  F_NONE);
					5'd14: r = mk(OP_MUL,  SL_QN,   SL_DT2,  SL_TB,   F_NONE);
					5'd15: r = mk(OP_HALF, SL_TB,   SL_ZERO, SL_TB,   F_NONE);
					5'd16: r = mk(OP_ADD,  SL_TC,   SL_TB,   SL_P01,  F_NONE);
					5'd17: r = mk(OP_MUL,  SL_QN,   SL_DT,   SL_TB,   F_NONE);
					5'd18: r = mk(OP_ADD,  SL_P11,  SL_TB,   SL_P11,  F_LAST);
					default: r = mk(OP_ADD, SL_ZERO, SL_ZERO, SL_TA, F_LAST);
				endcase
			end
			PG_UPDATE: begin
				case (s)
					5'd0:  r = mk(OP_ADD,  SL_ZERO, SL_ZERO, SL_K0,   F_NONE);
					5'd1:  r = mk(OP_ADD,  SL_ZERO, SL_ZERO, SL_K1,   F_NONE);
					5'd2:  r = mk(OP_ADD,  SL_P00,  SL_RN,   SL_S,    F_SETC);
					5'd3:  r = mk(OP_DIV,  SL_P00,  SL_S,    SL_K0,   F_COND);
					5'd4:  r = mk(OP_DIV,  SL_P01,  SL_S,    SL_K1,   F_COND);
					5'd5:  r = mk(OP_SUB,  SL_ZM,   SL_POS,  SL_Y,    F_NONE);
					5'd6:  r = mk(OP_MUL,  SL_K0,   SL_Y,    SL_TB,   F_NONE);
					5'd7:  r = mk(OP_ADD,  SL_POS,  SL_TB,   SL_POS,  F_NONE);
					5'd8:  r = mk(OP_MUL,  SL_K1,   SL_Y,    SL_TB,   F_NONE);
					5'd9:  r = mk(OP_ADD,  SL_RATE, SL_TB,   SL_RATE, F_NONE);
					5'd10: r = mk(OP_SUB,  SL_ONE,  SL_K0,   SL_OM,   F_NONE);
					5'd11: r = mk(OP_MUL,  SL_K1,   SL_P01,  SL_TB,   F_NONE);
					5'd12: r = mk(OP_SUB,  SL_P11,  SL_TB,   SL_P11,  F_NONE);
					5'd13: r = mk(OP_MUL,  SL_OM,   SL_P00,  SL_P00,  F_NONE);
					5'd14: r = mk(OP_MUL,  SL_OM,   SL_P01,  SL_P01,  F_LAST);
					default: r = mk(OP_ADD, SL_ZERO, SL_ZERO, SL_TA, F_LAST);
				endcase
			end
			PG_INIT: begin
				case (s)
					5'd0:  r = mk(OP_ADD,  SL_ZM,    SL_ZERO, SL_POS,  F_NONE);
					5'd1:  r = mk(OP_ADD,  SL_ZERO,  SL_ZERO, SL_RATE, F_NONE);
					5'd2:  r = mk(OP_ADD,  SL_RN,    SL_ZERO, SL_P00,  F_NONE);
					5'd3:  r = mk(OP_ADD,  SL_ZERO,  SL_ZERO, SL_P01,  F_NONE);
					5'd4:  r = mk(OP_ADD,  SL_K1000, SL_ZERO, SL_P11,  F_LAST);
					default: r = mk(OP_ADD, SL_ZERO, SL_ZERO, SL_TA, F_LAST);
				endcase
			end
			PG_REPORT: begin
				case (s)
					5'd0:  r = mk(OP_MUL,  SL_RATE, SL_HZ,   SL_TB,   F_NONE);
					5'd1:  r = mk(OP_ADD,  SL_POS,  SL_TB,   SL_FC,   F_NONE);
					5'd2:  r = mk(OP_MUL,  SL_HZ,   SL_P01,  SL_TA,   F_NONE);
					5'd3:  r = mk(OP_ADD,  SL_P00,  SL_TA,   SL_V,    F_NONE);
					5'd4:  r = mk(OP_ADD,  SL_V,    SL_TA,   SL_V,    F_NONE);
					5'd5:  r = mk(OP_MUL,  SL_HZ,   SL_HZ,   SL_H2,   F_NONE);
					5'd6:  r = mk(OP_MUL,  SL_H2,   SL_P11,  SL_TB,   F_NONE);
					5'd7:  r = mk(OP_ADD,  SL_V,    SL_TB,   SL_V,    F_NONE);
					5'd8:  r = mk(OP_SQRT, SL_V,    SL_ZERO, SL_SD,   F_LAST);
					default: r = mk(OP_ADD, SL_ZERO, SL_ZERO, SL_TA, F_LAST);
				endcase
			end
		endcase
		return r;
	endfunction

	function automatic logic [STATE_W-1:0] mag_of(logic signed [STATE_W-1:0] v);
		return v[STATE_W-1] ? (~v + 1'b1) : v;
	endfunction

	// magnitude and sign back to a saturated signed state value
	function automatic logic signed [STATE_W-1:0] sat_mag(logic [NUM_W-1:0] m, logic neg);
		logic [STATE_W-1:0] lo;
		lo = m[STATE_W-1:0];
		if (m > NUM_W'(ST_MAX))
			return neg ? ST_MIN : ST_MAX;
		return neg ? (~lo + 1'b1) : lo;
	endfunction

	// state format to signed q15.16, truncated toward zero and saturated
	function automatic logic [31:0] to_q16(logic signed [STATE_W-1:0] v);
		logic [STATE_W-1:0] m;
		m = mag_of(v) >> LIFT_SH;
		if (v[STATE_W-1]) begin
			if (m >= STATE_W'(32'h8000_0000))
				return 32'h8000_0000;
			return ~m[31:0] + 1'b1;
		end
		if (m > STATE_W'(32'h7FFF_FFFF))
			return 32'h7FFF_FFFF;
		return m[31:0];
	endfunction

endpackage

// ===== hw/rtl/kf2_opstore.sv =====
// kf2_opstore: operand store of the tracker, one write port and two registered read ports
// depends on kf2_pkg for widths
module kf2_opstore (
	input  logic                              clk,
	input  logic                              we,
	input  logic [kf2_pkg::SLOT_W-1:0]        waddr,
	input  logic signed [kf2_pkg::STATE_W-1:0] wdata,
	input  logic [kf2_pkg::SLOT_W-1:0]        raddr_a,
	input  logic [kf2_pkg::SLOT_W-1:0]        raddr_b,
	output logic signed [kf2_pkg::STATE_W-1:0] rdata_a,
	output logic signed [kf2_pkg::STATE_W-1:0] rdata_b
);

	logic signed [kf2_pkg::STATE_W-1:0] mem_q [2**kf2_pkg::SLOT_W];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== hw/rtl/kf2_alu.sv =====
// kf2_alu: shared arithmetic unit, saturating add and sub, halving, multi-cycle multiply,
// reciprocal divide by three, bit-serial divide and square root; depends on kf2_pkg
module kf2_alu (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  kf2_pkg::alu_op_t                   op,
	input  logic signed [kf2_pkg::STATE_W-1:0] a,
	input  logic signed [kf2_pkg::STATE_W-1:0] b,
	output logic                               done,
	output logic signed [kf2_pkg::STATE_W-1:0] result
);

	localparam int SW = kf2_pkg::STATE_W;
	localparam int HW = kf2_pkg::HALF_W;
	localparam int NW = kf2_pkg::NUM_W;
	localparam int AW = kf2_pkg::ACC_W;
	localparam int RW = kf2_pkg::RAD_W;
	localparam int TW = kf2_pkg::ROOT_W;
	localparam int FW = kf2_pkg::FRAC_W;
	// ceil(2^49 / 3): floor(m * THIRD_M >> 49) is m / 3 for any 48-bit magnitude
	localparam logic [SW-1:0] THIRD_M  = 48'hAAAA_AAAA_AAAB;
	localparam int            THIRD_SH = SW + 1;

	logic             busy_q, done_q;
	kf2_pkg::alu_op_t op_q;
	logic [6:0]       cnt_q;

	logic              neg_q;
	logic [SW-1:0]     ma_q, mb_q;
	logic [2*HW-1:0]   pp_q;
	logic [1:0]        pidx_q;
	logic [AW-1:0]     acc_q;
	logic [NW-1:0]     num_q, quo_q;
	logic [SW-1:0]     den_q, rem_q;
	logic [RW-1:0]     rad_q;
	logic [TW-1:0]     root_q;
	logic signed [SW-1:0] res_q;

	logic [SW-1:0]     ma, mb;
	logic signed [SW:0] sum_w, dif_w, half_w;
	logic signed [SW-1:0] add_r, sub_r;
	logic [HW-1:0]     pa, pb;
	logic [AW-1:0]     pp_sh, acc_nx;
	logic [SW:0]       rem2;
	logic              ge;
	logic [SW-1:0]     rem_nx;
	logic [NW-1:0]     quo_nx;
	logic [TW-1:0]     cand;
	logic [RW-1:0]     sq;
	logic              sq_ok;

	always_comb begin
		ma = kf2_pkg::mag_of(a);
		mb = kf2_pkg::mag_of(b);
		sum_w = {a[SW-1], a} + {b[SW-1], b};
		dif_w = {a[SW-1], a} - {b[SW-1], b};
		half_w = {a[SW-1], a} + (SW+1)'(a[SW-1]);
		// overflow shows as disagreement of the two top bits
		if (sum_w[SW] != sum_w[SW-1])
			add_r = sum_w[SW] ? kf2_pkg::ST_MIN : kf2_pkg::ST_MAX;
		else
			add_r = sum_w[SW-1:0];
		if (dif_w[SW] != dif_w[SW-1])
			sub_r = dif_w[SW] ? kf2_pkg::ST_MIN : kf2_pkg::ST_MAX;
		else
			sub_r = dif_w[SW-1:0];

		pa = cnt_q[1] ? ma_q[SW-1:HW] : ma_q[HW-1:0];
		pb = cnt_q[0] ? mb_q[SW-1:HW] : mb_q[HW-1:0];
		case (pidx_q) inside
			2'd0:       pp_sh = AW'(pp_q);
			2'd1, 2'd2: pp_sh = AW'(pp_q) << HW;
			default:    pp_sh = AW'(pp_q) << (2 * HW);
		endcase
		acc_nx = acc_q + pp_sh;

		rem2   = {rem_q, num_q[NW-1]};
		ge     = rem2 >= {1'b0, den_q};
		rem_nx = ge ? SW'(rem2 - {1'b0, den_q}) : rem2[SW-1:0];
		quo_nx = {quo_q[NW-2:0], ge};

		cand  = root_q | (TW'(1) << cnt_q[4:0]);
		sq    = cand * cand;
		sq_ok = sq <= rad_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= kf2_pkg::OP_ADD;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				op_q <= op;
				case (op) inside
					kf2_pkg::OP_MUL, kf2_pkg::OP_DIV3: begin
						busy_q <= 1'b1;
						cnt_q  <= '0;
					end
					kf2_pkg::OP_DIV: begin
						busy_q <= 1'b1;
						cnt_q  <= 7'(NW - 1);
					end
					kf2_pkg::OP_SQRT: begin
						busy_q <= 1'b1;
						cnt_q  <= 7'(TW - 1);
					end
					default: done_q <= 1'b1;
				endcase
			end else if (busy_q) begin
				case (op_q) inside
					kf2_pkg::OP_MUL, kf2_pkg::OP_DIV3: begin
						cnt_q <= cnt_q + 7'd1;
						if (cnt_q[2]) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					default: begin
						cnt_q <= cnt_q - 7'd1;
						if (cnt_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= ma;
			mb_q  <= (op == kf2_pkg::OP_DIV3) ? THIRD_M : mb;
			acc_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			root_q <= '0;
			case (op)
				kf2_pkg::OP_ADD:  res_q <= add_r;
				kf2_pkg::OP_SUB:  res_q <= sub_r;
				kf2_pkg::OP_HALF: res_q <= half_w[SW:1];
				kf2_pkg::OP_MUL:  neg_q <= a[SW-1] ^ b[SW-1];
				kf2_pkg::OP_DIV: begin
					neg_q <= a[SW-1];
					num_q <= {ma, FW'(0)};
					den_q <= b;
				end
				// magnitude times the reciprocal of three
				kf2_pkg::OP_DIV3: neg_q <= a[SW-1];
				kf2_pkg::OP_SQRT: begin
					// non-positive variance reads as zero
					if (!a[SW-1] && a != '0)
						rad_q <= RW'(a) << (RW - SW);
					else
						rad_q <= '0;
				end
				default: res_q <= '0;
			endcase
		end else if (busy_q) begin
			case (op_q) inside
				kf2_pkg::OP_MUL, kf2_pkg::OP_DIV3: begin
					if (!cnt_q[2]) begin
						pp_q   <= pa * pb;
						pidx_q <= cnt_q[1:0];
					end
					if (cnt_q != '0)
						acc_q <= acc_nx;
					if (cnt_q[2]) begin
						if (op_q == kf2_pkg::OP_MUL)
							res_q <= kf2_pkg::sat_mag(acc_nx[AW-1:FW], neg_q);
						else
							res_q <= kf2_pkg::sat_mag(NW'(acc_nx[AW-1:THIRD_SH]), neg_q);
					end
				end
				kf2_pkg::OP_DIV: begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					num_q <= {num_q[NW-2:0], 1'b0};
					if (cnt_q == '0)
						res_q <= kf2_pkg::sat_mag(quo_nx, neg_q);
				end
				default: begin
					if (sq_ok)
						root_q <= cand;
					if (cnt_q == '0)
						res_q <= SW'(sq_ok ? cand : root_q);
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== hw/rtl/kalman_filter_two_state.sv =====
// throughput: one item at a time; the next beat can be taken in the same cycle as the result is raised;
// the two bit-serial gain divisions and the bit-serial square root are the longest operations
// of the shared unit, ahead of a multiply, the divide by three and an add
// reset: asynchronous, active low; clears the filter to uninitialised, registers to defaults
module kalman_filter_two_state (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic signed [31:0] measurement,
	input  logic [23:0]        horizon,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] position,
	output logic signed [31:0] rate,
	output logic signed [31:0] forecast,
	output logic [31:0]        forecast_std,
	output logic               initialized
);

	localparam int SW = kf2_pkg::STATE_W;
	localparam int SL = kf2_pkg::SLOT_W;

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOAD  = 6'b000010,
		ST_FETCH = 6'b000100,
		ST_EXEC  = 6'b001000,
		ST_WAIT  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t         state_q;
	kf2_pkg::prog_t prog_q;
	logic [SL-1:0]  step_q;
	logic [2:0]     ld_cnt_q;
	logic           started_q;
	logic           cpos_q;      // innovation variance positive, gains enabled
	logic           out_valid_q;

	// config registers
	logic [23:0] dt_q;
	logic [31:0] qn_q, rn_q;

	// beat payload and captured results
	logic signed [31:0] meas_q;
	logic [23:0]        hor_q;
	logic [31:0]        pos_sh_q, rate_sh_q, fc_sh_q, sd_sh_q;
	logic [31:0]        pos_q, rate_q, fc_q, sd_q;
	logic               init_q;

	kf2_pkg::micro_t           mop;
	logic                      alu_done;
	logic signed [SW-1:0]      alu_res, rd_a, rd_b;
	logic                      st_we;
	logic [SL-1:0]             st_waddr, ld_addr;
	logic signed [SW-1:0]      st_wdata, ld_data;
	logic                      accept, wb;

	assign mop      = kf2_pkg::micro_of(prog_q, step_q);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign wb       = (state_q == ST_WAIT) && alu_done;

	// operands lifted into the state format at the start of each item
	always_comb begin
		case (ld_cnt_q)
			3'd0: begin ld_addr = kf2_pkg::SL_DT;   ld_data = SW'(dt_q) << kf2_pkg::LIFT_SH; end
			3'd1: begin ld_addr = kf2_pkg::SL_QN;   ld_data = SW'(qn_q) << kf2_pkg::LIFT_SH; end
			3'd2: begin ld_addr = kf2_pkg::SL_RN;   ld_data = SW'(rn_q) << kf2_pkg::LIFT_SH; end
			3'd3: begin ld_addr = kf2_pkg::SL_HZ;   ld_data = SW'(hor_q) << kf2_pkg::LIFT_SH; end
			3'd4: begin
				ld_addr = kf2_pkg::SL_ZM;
				ld_data = SW'(meas_q) <<< kf2_pkg::LIFT_SH;
			end
			3'd5: begin ld_addr = kf2_pkg::SL_ZERO; ld_data = '0; end
			3'd6: begin ld_addr = kf2_pkg::SL_ONE;  ld_data = SW'(1) << kf2_pkg::FRAC_W; end
			default: begin
				ld_addr = kf2_pkg::SL_K1000;
				ld_data = SW'(1000) << kf2_pkg::FRAC_W;
			end
		endcase
		st_we    = (state_q == ST_LOAD) || wb;
		st_waddr = (state_q == ST_LOAD) ? ld_addr : mop.dst;
		st_wdata = (state_q == ST_LOAD) ? ld_data : alu_res;
	end

	kf2_opstore u_store (
		.clk     (clk),
		.we      (st_we),
		.waddr   (st_waddr),
		.wdata   (st_wdata),
		.raddr_a (mop.src_a),
		.raddr_b (mop.src_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	kf2_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_EXEC),
		.op     (mop.op),
		.a      (rd_a),
		.b      (rd_b),
		.done   (alu_done),
		.result (alu_res)
	);

	// config writes, taken at any time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= 24'd655;
			qn_q <= 32'd65536;
			rn_q <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				kf2_pkg::CFG_TIME_STEP:  dt_q <= cfg_data[23:0];
				kf2_pkg::CFG_PROC_NOISE: qn_q <= cfg_data;
				kf2_pkg::CFG_MEAS_NOISE: rn_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prog_q      <= kf2_pkg::PG_REPORT;
			step_q      <= '0;
			ld_cnt_q    <= '0;
			started_q   <= 1'b0;
			cpos_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a result taken while the next one is ready is refilled in the finishing state
			if (out_valid_q && out_ready && (state_q != ST_DONE))
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						ld_cnt_q <= '0;
						step_q   <= '0;
						if (operation == kf2_pkg::OPC_UPDATE) begin
							prog_q  <= started_q ? kf2_pkg::PG_UPDATE : kf2_pkg::PG_INIT;
							state_q <= ST_LOAD;
						end else if (started_q) begin
							prog_q  <= (operation == kf2_pkg::OPC_PREDICT) ?
								kf2_pkg::PG_PREDICT : kf2_pkg::PG_REPORT;
							state_q <= ST_LOAD;
						end else begin
							// uninitialised: nothing to run, result is all zero
							state_q <= ST_DONE;
						end
					end
				end
				ST_LOAD: begin
					ld_cnt_q <= ld_cnt_q + 3'd1;
					if (ld_cnt_q == 3'd7)
						state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					// gain divisions are skipped when the innovation variance is not positive
					if (mop.cond && !cpos_q)
						step_q <= step_q + 1'b1;
					else
						state_q <= ST_EXEC;
				end
				ST_EXEC: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (alu_done) begin
						if (mop.setc)
							cpos_q <= !alu_res[SW-1] && (alu_res != '0);
						if (mop.last) begin
							if (prog_q == kf2_pkg::PG_REPORT) begin
								state_q <= ST_DONE;
							end else begin
								if (prog_q == kf2_pkg::PG_INIT)
									started_q <= 1'b1;
								prog_q  <= kf2_pkg::PG_REPORT;
								step_q  <= '0;
								state_q <= ST_FETCH;
							end
						end else begin
							step_q  <= step_q + 1'b1;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_DONE: begin
					// result register free or being taken this cycle
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			meas_q <= measurement;
			hor_q  <= horizon;
		end
		if (wb) begin
			case (mop.dst)
				kf2_pkg::SL_POS:  pos_sh_q  <= kf2_pkg::to_q16(alu_res);
				kf2_pkg::SL_RATE: rate_sh_q <= kf2_pkg::to_q16(alu_res);
				kf2_pkg::SL_FC:   fc_sh_q   <= kf2_pkg::to_q16(alu_res);
				kf2_pkg::SL_SD:   sd_sh_q   <= alu_res[31:0];
				default: ;
			endcase
		end
		if ((state_q == ST_DONE) && (!out_valid_q || out_ready)) begin
			pos_q  <= started_q ? pos_sh_q  : '0;
			rate_q <= started_q ? rate_sh_q : '0;
			fc_q   <= started_q ? fc_sh_q   : '0;
			sd_q   <= started_q ? sd_sh_q   : '0;
			// flag held with its beat, a later first measurement must not change it
			init_q <= started_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign position     = pos_q;
	assign rate         = rate_q;
	assign forecast     = fc_q;
	assign forecast_std = sd_q;
	assign initialized  = init_q;

`ifndef SYNTHESIS
	// once initialised the filter stays so until reset
	a_started_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(started_q))
		else $error("initialised flag dropped");

	// an accepted beat keeps the input closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input ready right after accept");

	// a result only appears out of the finishing state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result without finished item");
`endif

endmodule

// ===== sim/kalman_filter_two_state_tb.sv =====
// kalman_filter_two_state_tb: self-checking bench for the two-state kalman tracker
// predicts each result beat with a local fixed-point tracker model and compares it in a scoreboard
// depends on kf2_pkg and kalman_filter_two_state
module kalman_filter_two_state_tb;

	typedef logic signed [47:0] st_t;
	localparam st_t SMAX = {1'b0, {47{1'b1}}};
	localparam st_t SMIN = {1'b1, {47{1'b0}}};
	localparam logic [1:0] OPC_QUERY = 2'd2;
	localparam logic [1:0] OPC_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct packed {
		logic [31:0] pos;
		logic [31:0] rt;
		logic [31:0] fc;
		logic [31:0] sd;
		logic        init;
	} track_out_t;

	// saturate a wide signed value into the 48-bit state range
	function automatic st_t clamp(logic signed [199:0] v);
		if (v > 200'(signed'(SMAX))) return SMAX;
		if (v < 200'(signed'(SMIN))) return SMIN;
		return v[47:0];
	endfunction

	function automatic st_t add_s(st_t a, st_t b);
		return clamp(200'(a) + 200'(b));
	endfunction

	function automatic st_t sub_s(st_t a, st_t b);
		return clamp(200'(a) - 200'(b));
	endfunction

	// exact product, truncated toward zero to 24 fraction bits
	function automatic st_t fx_mul(st_t a, st_t b);
		logic signed [199:0] p;
		p = 200'(a) * 200'(b);
		return clamp(p / (200'sd1 <<< 24));
	endfunction

	function automatic st_t fx_div(st_t a, st_t d);
		return clamp((200'(a) <<< 24) / 200'(d));
	endfunction

	function automatic logic [31:0] out_q16(st_t v);
		logic signed [199:0] t;
		t = 200'(v) / 200'sd256;
		if (t > 200'sd2147483647) return 32'h7FFF_FFFF;
		if (t < -200'sd2147483648) return 32'h8000_0000;
		return t[31:0];
	endfunction

	function automatic logic [63:0] root_floor(logic [79:0] v);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 39; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (128'(c) * 128'(c) <= 128'(v)) r = c;
		end
		return r;
	endfunction

	class tracker_scoreboard;
		logic [23:0] dt_reg;
		logic [31:0] q_reg, r_reg;
		bit started;
		st_t xp, xr, p00, p01, p11;
		track_out_t pending[$];
		int mismatches;

		function void clear();
			dt_reg = 24'd655; q_reg = 32'd65536; r_reg = 32'd65536;
			started = 0; xp = 0; xr = 0; p00 = 0; p01 = 0; p11 = 0;
			pending.delete(); mismatches = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] v);
			case (idx)
				kf2_pkg::CFG_TIME_STEP:  dt_reg = v[23:0];
				kf2_pkg::CFG_PROC_NOISE: q_reg = v;
				kf2_pkg::CFG_MEAS_NOISE: r_reg = v;
				default: ;
			endcase
		endfunction

		// work out the expected result of one accepted input beat
		function void note_input(logic [1:0] op, logic signed [31:0] z_in, logic [23:0] hz_in);
			st_t dt, q, r, dt2, dt3, t, n00, n01, s, k0, k1, y, om, z, h, fc, v;
			logic [63:0] sd;
			track_out_t e;
			h = st_t'(hz_in) <<< 8;
			if (op == kf2_pkg::OPC_PREDICT && started) begin
				dt = st_t'(dt_reg) <<< 8;
				q = st_t'(q_reg) <<< 8;
				dt2 = fx_mul(dt, dt); dt3 = fx_mul(dt2, dt);
				t = fx_mul(dt, p01);
				n00 = add_s(add_s(add_s(p00, t), t), fx_mul(dt2, p11));
				n01 = add_s(p01, fx_mul(dt, p11));
				xp = add_s(xp, fx_mul(dt, xr));
				p00 = add_s(n00, fx_mul(q, dt3) / 3);
				p01 = add_s(n01, fx_mul(q, dt2) / 2);
				p11 = add_s(p11, fx_mul(q, dt));
			end else if (op == kf2_pkg::OPC_UPDATE) begin
				r = st_t'(r_reg) <<< 8;
				z = st_t'(z_in) <<< 8;
				if (!started) begin
					// first measurement seeds the filter
					xp = z; xr = 0; p00 = r; p01 = 0;
					p11 = st_t'(1000) <<< 24; started = 1;
				end else begin
					s = add_s(p00, r);
					k0 = 0; k1 = 0;
					if (s > 0) begin
						k0 = fx_div(p00, s); k1 = fx_div(p01, s);
					end
					y = sub_s(z, xp);
					xp = add_s(xp, fx_mul(k0, y));
					xr = add_s(xr, fx_mul(k1, y));
					om = sub_s(st_t'(1) <<< 24, k0);
					p11 = sub_s(p11, fx_mul(k1, p01));
					p00 = fx_mul(om, p00);
					p01 = fx_mul(om, p01);
				end
			end
			fc = add_s(xp, fx_mul(xr, h));
			t = fx_mul(h, p01);
			v = add_s(add_s(add_s(p00, t), t), fx_mul(fx_mul(h, h), p11));
			sd = 0;
			if (v > 0) sd = root_floor(80'(v) << 8);
			e.pos = out_q16(xp); e.rt = out_q16(xr); e.fc = out_q16(fc);
			e.sd = (sd > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sd[31:0];
			e.init = started;
			pending.push_back(e);
		endfunction

		function void check_result(track_out_t got);
			track_out_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", got);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %h %h %h %h %b, got %h %h %h %h %b",
						e.pos, e.rt, e.fc, e.sd, e.init,
						got.pos, got.rt, got.fc, got.sd, got.init);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = kf2_pkg::CFG_TIME_STEP;
	logic [31:0] cfg_data = '0;
	logic in_valid = 0, in_ready;
	logic [1:0] operation = OPC_QUERY;
	logic signed [31:0] measurement = '0;
	logic [23:0] horizon = '0;
	logic out_valid, out_ready = 0;
	logic signed [31:0] position, rate, forecast;
	logic [31:0] forecast_std;
	logic initialized;

	tracker_scoreboard sb = new();
	int send_idle = 0, recv_stall = 0;
	int hold_off = 0;
	int cycles = 0;

	kalman_filter_two_state DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// receiver: random stalls, plus a long hold-off counted here
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result({position, rate, forecast, forecast_std, initialized});
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 0;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		sb.set_reg(idx, v);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// offer one beat, with an optional idle gap before it; valid stays up between beats
	task automatic send_beat(logic [1:0] op, logic signed [31:0] z, logic [23:0] hz);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		in_valid <= 1; operation <= op; measurement <= z; horizon <= hz;
		do @(posedge clk); while (!in_ready);
		sb.note_input(op, z, hz);
	endtask

	// wait for every expected beat, then let the block settle before a write
	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic random_beats(int n);
		logic [1:0] op;
		logic [31:0] z;
		logic [23:0] hz;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: op = kf2_pkg::OPC_PREDICT;
				4, 5, 6, 7: op = kf2_pkg::OPC_UPDATE;
				8: op = OPC_QUERY;
				default: op = OPC_SPARE;
			endcase
			// mostly modest values for realistic tracks, sometimes full range
			z = ($urandom_range(7) == 0) ? $urandom : 32'($signed($urandom_range(2000000)) - 1000000);
			hz = ($urandom_range(7) == 0) ? 24'($urandom) : 24'($urandom_range(131072));
			send_beat(op, z, hz);
		end
	endtask

	initial begin
		sb.clear();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: queries and ticks before the first measurement, then the extremes
		send_beat(OPC_QUERY, 32'sd0, 24'hFFFFFF);
		send_beat(kf2_pkg::OPC_PREDICT, 32'sd5, 24'd65536);
		send_beat(OPC_SPARE, 32'sd7, 24'd0);
		send_beat(kf2_pkg::OPC_UPDATE, 32'sh7FFFFFFF, 24'd0);
		send_beat(OPC_QUERY, 32'sd0, 24'hFFFFFF);
		send_beat(kf2_pkg::OPC_PREDICT, 32'sd0, 24'd65536);
		send_beat(kf2_pkg::OPC_UPDATE, 32'sh80000000, 24'hFFFFFF);
		send_beat(kf2_pkg::OPC_UPDATE, 32'sd0, 24'd1);
		send_beat(OPC_SPARE, 32'shFFFFFFFF, 24'h800000);
		drain();

		// zero noise: innovation variance can become non-positive
		write_reg(kf2_pkg::CFG_MEAS_NOISE, 32'd0);
		write_reg(kf2_pkg::CFG_PROC_NOISE, 32'd0);
		write_reg(kf2_pkg::CFG_TIME_STEP, 24'd0);
		send_beat(kf2_pkg::OPC_UPDATE, 32'sd65536, 24'd0);
		send_beat(kf2_pkg::OPC_PREDICT, 32'sd0, 24'd65536);
		send_beat(kf2_pkg::OPC_UPDATE, 32'sd65536, 24'd0);
		drain();

		// maximum registers
		write_reg(kf2_pkg::CFG_TIME_STEP, 32'hFFFFFF);
		write_reg(kf2_pkg::CFG_PROC_NOISE, 32'hFFFFFFFF);
		write_reg(kf2_pkg::CFG_MEAS_NOISE, 32'hFFFFFFFF);
		send_beat(kf2_pkg::OPC_PREDICT, 32'sd0, 24'hFFFFFF);
		send_beat(kf2_pkg::OPC_UPDATE, 32'sh12345678, 24'h5A5A5A);
		send_beat(kf2_pkg::OPC_PREDICT, 32'sd0, 24'hA5A5A5);
		drain();

		// random phases over several settings and idling patterns
		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 75; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 75; end
				default: begin send_idle = 14; recv_stall = 14; end
			endcase
			write_reg(kf2_pkg::CFG_TIME_STEP,
				(ph == 5) ? 32'($urandom) : 32'($urandom_range(20000)));
			write_reg(kf2_pkg::CFG_PROC_NOISE,
				(ph == 4) ? $urandom : 32'($urandom_range(200000)));
			write_reg(kf2_pkg::CFG_MEAS_NOISE,
				(ph == 3) ? $urandom : 32'($urandom_range(300000)));
			if (ph == 2) hold_off = 2000;
			random_beats(95);
			drain();
		end

		if (sb.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
